// ===== design/ppq_pkg.sv =====
// Package: constants, request/response types and controller encodings for the playback queue.
`timescale 1ns / 1ps
`default_nettype none
package ppq_pkg;

    localparam int PRIORITY_LEVELS = 8;
    localparam int QUEUE_DEPTH     = 16;

    localparam int LVL_W   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_N = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(STORE_N);
    localparam int CLIP_W  = 16;
    localparam int PRIO_W  = 3;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [PRIO_W-1:0] priority_req;
        logic [CLIP_W-1:0] clip_id;
    } t_req;

    typedef struct packed {
        logic              play_valid;
        logic [CLIP_W-1:0] play_id;
        logic              stop_current;
        logic              dropped;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_FIN_RD,
        ST_FIN_CMP,
        ST_READ,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request, clear per-request flags
        logic enq;       // append to level FIFO or flag a drop
        logic rd_issue;  // pick first non-empty level, read its head
        logic pop_chk;   // pop head if it matches the finished clip
        logic out_load;  // load the result register and strobe
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/ppq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/ppq_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module ppq_ctrl
    import ppq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic i_action,
    output logic      busy,
    output t_cmd      o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_action == ACT_FINISH) ? ST_FIN_RD : ST_ENQ;
                end
            end
            ST_ENQ: begin
                o_cmd.enq = 1'b1;
                n_state = ST_READ;
            end
            ST_FIN_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_FIN_CMP;
            end
            ST_FIN_CMP: begin
                o_cmd.pop_chk = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/ppq_dp.sv =====
// Datapath: per-level FIFO pointers and counts, clip store, level select and result register.
`timescale 1ns / 1ps
`default_nettype none
module ppq_dp
    import ppq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_rsp      o_rsp,
    output logic      o_strobe
);
    t_req              r_req;
    logic [LVL_W-1:0]  r_lvl;
    logic [PTR_W-1:0]  r_head  [PRIORITY_LEVELS];
    logic [PTR_W-1:0]  r_tail  [PRIORITY_LEVELS];
    logic [CNT_W-1:0]  r_count [PRIORITY_LEVELS];
    logic              r_playing;
    logic              r_stop;
    logic              r_drop;
    logic              r_found;
    logic [LVL_W-1:0]  r_first;
    t_rsp              r_rsp;
    logic              r_strobe;

    logic              first_found;
    logic [LVL_W-1:0]  first_lvl;
    logic [LVL_W-1:0]  req_lvl;
    logic              lvl_full;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CLIP_W-1:0] ram_rdata;
    logic              head_match;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Lowest non-empty level wins
    always_comb begin
        first_found = 1'b0;
        first_lvl   = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                first_found = 1'b1;
                first_lvl   = LVL_W'(i);
            end
        end
    end

    // Out-of-range levels saturate to the last one
    assign req_lvl = (int'(i_req.priority_req) >= PRIORITY_LEVELS) ?
                     LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(i_req.priority_req);

    assign lvl_full   = (r_count[r_lvl] >= CNT_W'(QUEUE_DEPTH));
    assign ram_we     = i_cmd.enq && !lvl_full;
    assign ram_waddr  = ADDR_W'(r_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[r_lvl]);
    assign ram_raddr  = ADDR_W'(first_lvl) * ADDR_W'(QUEUE_DEPTH)
                      + ADDR_W'(r_head[first_lvl]);
    assign head_match = r_found && (ram_rdata == r_req.clip_id);

    ppq_ram #(
        .WIDTH (CLIP_W),
        .DEPTH (STORE_N)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.clip_id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request, level select and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_lvl <= req_lvl;
        end
        if (i_cmd.rd_issue) begin
            r_found <= first_found;
            r_first <= first_lvl;
        end
        if (i_cmd.out_load) begin
            r_rsp.play_valid   <= r_found;
            r_rsp.play_id      <= r_found ? ram_rdata : '0;
            r_rsp.stop_current <= r_stop;
            r_rsp.dropped      <= r_drop;
        end
    end

    // FIFO bookkeeping and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_playing <= 1'b0;
            r_stop    <= 1'b0;
            r_drop    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_load;
            if (i_cmd.capture) begin
                r_stop <= 1'b0;
                r_drop <= 1'b0;
            end
            if (i_cmd.enq) begin
                r_stop <= r_playing;
                if (lvl_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_tail[r_lvl]  <= next_slot(r_tail[r_lvl]);
                    r_count[r_lvl] <= r_count[r_lvl] + 1'b1;
                end
            end
            if (i_cmd.pop_chk && head_match) begin
                r_head[r_first]  <= next_slot(r_head[r_first]);
                r_count[r_first] <= r_count[r_first] - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_playing <= r_found;
            end
        end
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;
endmodule
`default_nettype wire

// ===== design/priority_playback_queue.sv =====
// Top level of the strict-priority playback queue: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Strict-priority playback scheduler. A request is taken when start is high
// and busy is low; each request yields exactly one result, shown on o_rsp for
// a single cycle with o_strobe high. The receiver cannot stall, so it must
// take the result in that cycle. An enqueue passes through the ENQ, READ and OUT
// states after the accept cycle, and a finish through FIN_RD, FIN_CMP, READ and
// OUT; the result strobes in the first cycle with busy low, and a new request may
// be taken in that same cycle. The sequence is set by the clip store's registered
// read: each head lookup's data is usable only once the read is registered, and a
// finish needs two lookups (match check, then the new head). Full levels drop the
// clip and set dropped; the preempt and restart still happen.
module priority_playback_queue
    import ppq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output t_rsp      o_rsp,
    output logic      o_strobe
);
    t_cmd cmd;

    // sequencing: one request at a time
    ppq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_req.action),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // level FIFOs, clip store and result register
    ppq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );
endmodule
`default_nettype wire

// ===== test/tb_priority_playback_queue.sv =====
// Self-checking testbench for the strict-priority playback queue.
`timescale 1ns / 1ps
module tb_priority_playback_queue;
    import ppq_pkg::*;

    // Tracks per-level clip FIFOs as the block should see them. Every accepted
    // request is turned into its expected result at once; results are then
    // matched in order against what the block strobes out.
    class playback_scoreboard;
        logic [CLIP_W-1:0] level_clips [PRIORITY_LEVELS][$];
        bit                now_playing;
        t_rsp              expected_rsp [$];
        int                fails;
        int                checked;
        int                enqueues;
        int                finishes;
        int                drops;

        // lowest non-empty level, PRIORITY_LEVELS when all are empty
        function int first_active_level();
            for (int l = 0; l < PRIORITY_LEVELS; l++)
                if (level_clips[l].size() != 0)
                    return l;
            return PRIORITY_LEVELS;
        endfunction

        function t_rsp schedule(t_req r);
            t_rsp rsp;
            int   lvl;
            rsp = '0;
            if (r.action == ACT_ENQUEUE) begin
                lvl = int'(r.priority_req);
                if (lvl >= PRIORITY_LEVELS)
                    lvl = PRIORITY_LEVELS - 1;
                if (level_clips[lvl].size() >= QUEUE_DEPTH)
                    rsp.dropped = 1'b1;
                else
                    level_clips[lvl] = {level_clips[lvl], r.clip_id};
                rsp.stop_current = now_playing;
            end else begin
                // pop only when the finished clip is the one at the head
                lvl = first_active_level();
                if (lvl < PRIORITY_LEVELS && level_clips[lvl][0] == r.clip_id)
                    void'(level_clips[lvl].pop_front());
            end
            lvl = first_active_level();
            if (lvl < PRIORITY_LEVELS) begin
                rsp.play_valid = 1'b1;
                rsp.play_id    = level_clips[lvl][0];
            end
            now_playing = rsp.play_valid;
            return rsp;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp = schedule(r);
            expected_rsp = {expected_rsp, rsp};
            if (r.action == ACT_ENQUEUE)
                enqueues++;
            else
                finishes++;
            if (rsp.dropped)
                drops++;
        endfunction

        // clip the block should be playing right now, if any
        function bit head_now(output logic [CLIP_W-1:0] id);
            int lvl;
            lvl = first_active_level();
            id  = '0;
            if (lvl == PRIORITY_LEVELS)
                return 1'b0;
            id = level_clips[lvl][0];
            return 1'b1;
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp_r;
            if (expected_rsp.size() == 0) begin
                $display("%0t: result with no request pending: expected none, got %h",
                         $time, got);
                fails++;
                return;
            end
            exp_r = expected_rsp.pop_front();
            checked++;
            compare_field("play_valid",   exp_r.play_valid,   got.play_valid);
            compare_field("play_id",      exp_r.play_id,      got.play_id);
            compare_field("stop_current", exp_r.stop_current, got.stop_current);
            compare_field("dropped",      exp_r.dropped,      got.dropped);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    t_rsp o_rsp;
    logic o_strobe;

    playback_scoreboard sb;

    priority_playback_queue DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Results last a single cycle and cannot be stalled: sample on every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_rsp);
    end

    function t_req make_req(logic act, int prio, int id);
        t_req r;
        r.action       = act;
        r.priority_req = PRIO_W'(prio);
        r.clip_id      = CLIP_W'(id);
        return r;
    endfunction

    // Hold the request until the block takes it (start high, busy low at an edge).
    // start stays high on return so back-to-back requests need no re-raise.
    task automatic issue_request(t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random traffic. Most finishes name the current head so the FIFOs drain
    // in order; one level is favored per phase so it fills up and drops.
    task automatic run_phase(int n_items, int idle_pct);
        int                hot;
        int                pick;
        int                prio;
        int                id;
        bit                has_head;
        logic [CLIP_W-1:0] head_id;
        t_req              r;
        hot = $urandom_range(0, PRIORITY_LEVELS - 1);
        for (int i = 0; i < n_items; i++) begin
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                idle_cycles($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            // small id pool now and then so duplicates show up
            id   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
            prio = ($urandom_range(0, 1) == 0) ? hot : $urandom_range(0, 7);
            has_head = sb.head_now(head_id);
            if (pick < 46)
                r = make_req(ACT_ENQUEUE, prio, id);
            else if (pick < 86 && has_head)
                r = make_req(ACT_FINISH, $urandom_range(0, 7), head_id);
            else
                r = make_req(ACT_FINISH, $urandom_range(0, 7), id);
            issue_request(r);
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: finish with every level empty
        issue_request(make_req(ACT_FINISH, 0, 16'h1234));
        // enqueue while idle, then a higher-priority clip preempts it
        issue_request(make_req(ACT_ENQUEUE, 7, 16'hFFFF));
        issue_request(make_req(ACT_ENQUEUE, 0, 16'h0000));
        // finish naming a clip that is not the head: nothing leaves
        issue_request(make_req(ACT_FINISH, 5, 16'hABCD));
        // real finish; level field is ignored, lowest level falls back to 7
        issue_request(make_req(ACT_FINISH, 7, 16'h0000));
        // fill level 7 to the brim, then one more is refused
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            issue_request(make_req(ACT_ENQUEUE, 7, $urandom_range(0, 65535)));
        issue_request(make_req(ACT_ENQUEUE, 7, 16'h5555));
        // duplicate ids: each finish removes one copy
        issue_request(make_req(ACT_ENQUEUE, 0, 16'hAAAA));
        issue_request(make_req(ACT_ENQUEUE, 0, 16'hAAAA));
        issue_request(make_req(ACT_FINISH, 3, 16'hAAAA));
        issue_request(make_req(ACT_FINISH, 0, 16'hAAAA));

        // Random phases: no gaps, heavy gaps, no gaps, light gaps
        run_phase(256, 0);
        run_phase(256, 49);
        run_phase(256, 0);
        run_phase(256, 17);
        start <= 1'b0;

        for (int w = 0; w < 200 && sb.expected_rsp.size() != 0; w++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.expected_rsp.size() != 0) begin
            $display("%0t: %0d results never arrived: expected %0d more, got 0",
                     $time, sb.expected_rsp.size(), sb.expected_rsp.size());
            sb.fails++;
        end

        $display("Ran %0d requests (%0d enqueue, %0d finish), %0d results checked, %0d drops.",
                 sb.enqueues + sb.finishes, sb.enqueues, sb.finishes, sb.checked, sb.drops);
        $display("Phases: back-to-back, 49%% sender gaps, back-to-back, 17%% sender gaps.");
        if (sb.fails == 0)
            $display("[priority_playback_queue] OK");
        else
            $display("[priority_playback_queue] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[priority_playback_queue] ERROR");
        $finish;
    end

endmodule
